/* hw/rtl/wsbf_pkg.sv */
`default_nettype none

package wsbf_pkg;

   localparam int MAX_WORKERS = 64;
   localparam int ID_W        = 6;
   localparam int CNT_W       = 7;
   localparam int FUNC_W      = 2;
   localparam int DIV_STEPS   = ID_W / 2;
   localparam int STEP_W      = 2;

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_WORKERS);

   localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;

   typedef logic [MAX_WORKERS-1:0] map_type;

   typedef struct packed {
      logic            found;
      logic [ID_W-1:0] index;
   } hit_type;

   typedef struct packed {
      logic accept;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // bits strictly below n
   function automatic map_type below_mask(input logic [CNT_W-1:0] n);
      map_type m;
      for (int i = 0; i < MAX_WORKERS; i++) begin
         m[i] = CNT_W'(i) < n;
      end
      return m;
   endfunction

   // bits at or above idx
   function automatic map_type from_mask(input logic [CNT_W-1:0] idx);
      map_type m;
      for (int i = 0; i < MAX_WORKERS; i++) begin
         m[i] = CNT_W'(i) >= idx;
      end
      return m;
   endfunction

   function automatic hit_type find_first(input map_type v);
      hit_type h;
      h.found = 1'b0;
      h.index = '0;
      for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
         if (v[i]) begin
            h.found = 1'b1;
            h.index = ID_W'(i);
         end
      end
      return h;
   endfunction

   // circular search from idx: upper part first, then wrap to the bottom
   function automatic hit_type find_circular(input map_type cand,
                                             input logic [CNT_W-1:0] idx);
      hit_type hi;
      hit_type all;
      hi  = find_first(cand & from_mask(idx));
      all = find_first(cand);
      return hi.found ? hi : all;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/work_steal_bitmap_finder.sv */
`default_nettype none

// Work-steal flag map with victim and free-worker search. Each request marks,
// clears or only tests one worker's flag, then returns one response against the
// updated map: the worker's flag, whether any flag below the worker count is
// set, the first flagged worker circularly after the requester, and the first
// unflagged worker circularly from start_req modulo the count. The flag update
// lands at the accepting edge; the start index is then reduced in the division
// steps (two dividend bits per cycle), and a final state runs both circular
// searches and loads the result into the output register. No new request is
// taken until then. The next request is accepted once the response is loaded,
// even while it still waits for rsp_ready; its result then holds until the
// output register frees up. The worker count (csr_wr_data) resets to 64; the
// user must write it only while the block is idle, which the block itself does
// not enforce.
module work_steal_bitmap_finder
   import wsbf_pkg::*;
(
   input  wire              clock,
   input  wire              reset,
   input  wire              csr_wr_en,
   input  wire [CNT_W-1:0]  csr_wr_data,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire [FUNC_W-1:0] req_func,
   input  wire [ID_W-1:0]   req_worker_id,
   input  wire [ID_W-1:0]   req_start_req,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output logic             rsp_is_marked,
   output logic             rsp_any_marked,
   output logic             rsp_victim_found,
   output logic [ID_W-1:0]  rsp_victim_index,
   output logic             rsp_free_found,
   output logic [ID_W-1:0]  rsp_free_index
);

   cmd_type    cmd;
   status_type status;

   wsbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wsbf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_func         (req_func),
      .req_worker_id    (req_worker_id),
      .req_start_req    (req_start_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_marked    (rsp_is_marked),
      .rsp_any_marked   (rsp_any_marked),
      .rsp_victim_found (rsp_victim_found),
      .rsp_victim_index (rsp_victim_index),
      .rsp_free_found   (rsp_free_found),
      .rsp_free_index   (rsp_free_index)
   );

endmodule

`default_nettype wire

/* hw/rtl/wsbf_ctrl.sv */
`default_nettype none

module wsbf_ctrl
   import wsbf_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.accept   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/wsbf_dp.sv */
`default_nettype none

module wsbf_dp
   import wsbf_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  wire               csr_wr_en,
   input  wire [CNT_W-1:0]   csr_wr_data,
   input  wire [FUNC_W-1:0]  req_func,
   input  wire [ID_W-1:0]    req_worker_id,
   input  wire [ID_W-1:0]    req_start_req,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic              rsp_is_marked,
   output logic              rsp_any_marked,
   output logic              rsp_victim_found,
   output logic [ID_W-1:0]   rsp_victim_index,
   output logic              rsp_free_found,
   output logic [ID_W-1:0]   rsp_free_index
);

   logic [CNT_W-1:0] count_ff;
   map_type          flags_ff, flags_in;
   logic [ID_W-1:0]  id_ff;
   logic [ID_W-1:0]  start_ff, start_in;
   logic [ID_W-1:0]  rem_ff, rem_in;

   logic             valid_ff, valid_in;
   logic             is_marked_ff, any_ff, vfound_ff, ffound_ff;
   logic [ID_W-1:0]  vidx_ff, fidx_ff;

   logic [CNT_W-1:0] eff_n;
   map_type          live;
   logic             req_id_ok;
   logic             id_ok;
   logic [CNT_W-1:0] r1, r1s, r2, r2s;
   map_type          id_bit;
   hit_type          victim;
   hit_type          free_hit;

   assign eff_n = (count_ff > CNT_W'(MAX_WORKERS)) ? CNT_W'(MAX_WORKERS) : count_ff;
   assign live  = below_mask(eff_n);

   assign req_id_ok = {1'b0, req_worker_id} < eff_n;
   assign id_ok     = {1'b0, id_ff} < eff_n;

   always_comb begin
      flags_in = flags_ff;
      if (cmd.accept && req_id_ok) begin
         if (req_func == FUNC_MARK) begin
            flags_in[req_worker_id] = 1'b1;
         end else if (req_func == FUNC_CLEAR) begin
            flags_in[req_worker_id] = 1'b0;
         end
      end
   end

   // remainder of start by the count, two dividend bits per step
   always_comb begin
      r1  = {rem_ff, start_ff[ID_W-1]};
      r1s = (r1 >= eff_n) ? r1 - eff_n : r1;
      r2  = {r1s[ID_W-1:0], start_ff[ID_W-2]};
      r2s = (r2 >= eff_n) ? r2 - eff_n : r2;
      rem_in   = rem_ff;
      start_in = start_ff;
      if (cmd.accept) begin
         rem_in   = '0;
         start_in = req_start_req;
      end else if (cmd.div_step) begin
         rem_in   = r2s[ID_W-1:0];
         start_in = {start_ff[ID_W-3:0], 2'b00};
      end
   end

   always_comb begin
      id_bit          = '0;
      id_bit[id_ff]   = 1'b1;
      victim   = find_circular(flags_ff & live & ~id_bit, {1'b0, id_ff} + CNT_W'(1));
      free_hit = find_circular(~flags_ff & live, {1'b0, rem_ff});
   end

   assign status.out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         flags_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         flags_ff <= flags_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         id_ff <= req_worker_id;
      end
      start_ff <= start_in;
      rem_ff   <= rem_in;
      if (cmd.load_out) begin
         is_marked_ff <= id_ok && flags_ff[id_ff];
         any_ff       <= |(flags_ff & live);
         // drop the victim when the requester is outside the count
         vfound_ff    <= id_ok && victim.found;
         vidx_ff      <= id_ok ? victim.index : '0;
         ffound_ff    <= free_hit.found;
         fidx_ff      <= free_hit.index;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_is_marked    = is_marked_ff;
   assign rsp_any_marked   = any_ff;
   assign rsp_victim_found = vfound_ff;
   assign rsp_victim_index = vidx_ff;
   assign rsp_free_found   = ffound_ff;
   assign rsp_free_index   = fidx_ff;

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench
   import wsbf_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int REPORT_LIMIT = 10;
   localparam int PHASES = 12;
   localparam int PHASE_REQUESTS = 160;

   typedef struct {
      logic            is_marked;
      logic            any_marked;
      logic            victim_found;
      logic [ID_W-1:0] victim_index;
      logic            free_found;
      logic [ID_W-1:0] free_index;
   } steal_report_type;

   class steal_map_checker;
      map_type           flags;
      logic [CNT_W-1:0]  active_count;
      steal_report_type  pending_reports[$];
      int                mismatches;

      function new();
         flags = '0;
         active_count = COUNT_RESET;
         mismatches = 0;
      endfunction

      // apply the flag update, then search the updated map
      function void note_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                 logic [ID_W-1:0] start);
         steal_report_type r;
         int n;
         int s;
         int j;
         bit id_ok;
         n = (int'(active_count) > MAX_WORKERS) ? MAX_WORKERS : int'(active_count);
         id_ok = int'(id) < n;
         r = '{default: '0};
         if (id_ok) begin
            if (func == FUNC_MARK) flags[id] = 1'b1;
            else if (func == FUNC_CLEAR) flags[id] = 1'b0;
            r.is_marked = flags[id];
         end
         for (int k = 0; k < n; k++) begin
            if (flags[k]) r.any_marked = 1'b1;
         end
         if (n > 1 && id_ok) begin
            for (int k = 1; k < n; k++) begin
               j = (int'(id) + k) % n;
               if (flags[j] && !r.victim_found) begin
                  r.victim_found = 1'b1;
                  r.victim_index = ID_W'(j);
               end
            end
         end
         if (n > 0) begin
            s = int'(start) % n;
            for (int k = 0; k < n; k++) begin
               j = (s + k) % n;
               if (!flags[j] && !r.free_found) begin
                  r.free_found = 1'b1;
                  r.free_index = ID_W'(j);
               end
            end
         end
         pending_reports.push_back(r);
      endfunction

      function void check_report(steal_report_type got);
         steal_report_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("response with no request outstanding: marked=%0d any=%0d",
                        got.is_marked, got.any_marked);
            return;
         end
         want = pending_reports.pop_front();
         if (got.is_marked !== want.is_marked || got.any_marked !== want.any_marked ||
             got.victim_found !== want.victim_found ||
             got.victim_index !== want.victim_index ||
             got.free_found !== want.free_found || got.free_index !== want.free_index) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("response mismatch: expected marked=%0d any=%0d victim=%0d/%0d free=%0d/%0d",
                        want.is_marked, want.any_marked, want.victim_found,
                        want.victim_index, want.free_found, want.free_index);
               $display("                   got      marked=%0d any=%0d victim=%0d/%0d free=%0d/%0d",
                        got.is_marked, got.any_marked, got.victim_found,
                        got.victim_index, got.free_found, got.free_index);
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [CNT_W-1:0]  csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [FUNC_W-1:0] req_func = '0;
   logic [ID_W-1:0]   req_worker_id = '0;
   logic [ID_W-1:0]   req_start_req = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_is_marked;
   logic              rsp_any_marked;
   logic              rsp_victim_found;
   logic [ID_W-1:0]   rsp_victim_index;
   logic              rsp_free_found;
   logic [ID_W-1:0]   rsp_free_index;

   steal_map_checker sb;
   int cur_count = MAX_WORKERS;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int rsp_hold_cycles = 0;

   work_steal_bitmap_finder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_worker_id    (req_worker_id),
      .req_start_req    (req_start_req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_marked    (rsp_is_marked),
      .rsp_any_marked   (rsp_any_marked),
      .rsp_victim_found (rsp_victim_found),
      .rsp_victim_index (rsp_victim_index),
      .rsp_free_found   (rsp_free_found),
      .rsp_free_index   (rsp_free_index)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_request(req_func, req_worker_id, req_start_req);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_report('{rsp_is_marked, rsp_any_marked, rsp_victim_found,
                           rsp_victim_index, rsp_free_found, rsp_free_index});
   end

   task automatic send_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                               logic [ID_W-1:0] start);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_worker_id <= id;
      req_start_req <= start;
      do @(posedge clock); while (!req_ready);
   endtask

   // change the count only once every response is back
   task automatic set_worker_count(logic [CNT_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.active_count = value;
      cur_count = (int'(value) > MAX_WORKERS) ? MAX_WORKERS : int'(value);
   endtask

   function automatic logic [FUNC_W-1:0] pick_func(int mark_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) return FUNC_SPARE;
      if (r < 14) return FUNC_QUERY;
      return ($urandom_range(0, 99) < mark_pct) ? FUNC_MARK : FUNC_CLEAR;
   endfunction

   // mostly ids in range, some anywhere in the field
   function automatic logic [ID_W-1:0] pick_worker();
      if (cur_count > 0 && $urandom_range(0, 99) < 85)
         return ID_W'($urandom_range(0, cur_count - 1));
      return ID_W'($urandom_range(0, 63));
   endfunction

   initial begin
      int stall;
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = rsp_steady ? 0 : $urandom_range(0, 7);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int phase_count[PHASES];
      int phase_mark[PHASES];
      phase_count = '{64, 2, 127, 5, 0, 1, 33, 64, 63, 3, 17, 64};
      phase_mark  = '{50, 60, 70, 90, 50, 30, 40, 90, 85, 50, 20, 10};
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty map, wrap of both searches, unused func
      send_request(FUNC_QUERY, 6'd0, 6'd0);
      send_request(FUNC_MARK, 6'd63, 6'd63);
      send_request(FUNC_MARK, 6'd0, 6'd0);
      send_request(FUNC_QUERY, 6'd63, 6'd63);
      send_request(FUNC_QUERY, 6'd0, 6'd0);
      send_request(FUNC_CLEAR, 6'd63, 6'd1);
      send_request(FUNC_SPARE, 6'd0, 6'd63);
      send_request(FUNC_MARK, 6'd42, 6'd42);
      send_request(FUNC_CLEAR, 6'd0, 6'd0);

      // full map below the count, ids out of range
      set_worker_count(7'd3);
      send_request(FUNC_MARK, 6'd0, 6'd0);
      send_request(FUNC_MARK, 6'd1, 6'd1);
      send_request(FUNC_MARK, 6'd2, 6'd63);
      send_request(FUNC_QUERY, 6'd5, 6'd5);
      send_request(FUNC_MARK, 6'd63, 6'd62);
      send_request(FUNC_CLEAR, 6'd1, 6'd2);

      // single worker: no victim possible
      set_worker_count(7'd1);
      send_request(FUNC_QUERY, 6'd0, 6'd63);
      send_request(FUNC_CLEAR, 6'd0, 6'd7);
      send_request(FUNC_MARK, 6'd1, 6'd0);

      // no workers: nothing found, start left as is
      set_worker_count(7'd0);
      send_request(FUNC_MARK, 6'd0, 6'd63);
      send_request(FUNC_QUERY, 6'd0, 6'd21);

      // count above the map width acts as the full map
      set_worker_count(7'd127);
      send_request(FUNC_QUERY, 6'd63, 6'd63);
      send_request(FUNC_CLEAR, 6'd42, 6'd42);

      for (int p = 0; p < PHASES; p++) begin
         set_worker_count(CNT_W'(phase_count[p]));
         req_steady = (p % 4 == 1);
         rsp_steady = (p % 4 == 1) || (p % 4 == 2);
         // stall the receiver long enough for the block to back up its input
         if (p == 7) begin
            req_steady = 1'b1;
            rsp_hold_cycles = 300;
         end
         repeat (PHASE_REQUESTS)
            send_request(pick_func(phase_mark[p]), pick_worker(),
                         ID_W'($urandom_range(0, 63)));
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (sb.pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
